@@ sv/rfps_pkg.sv @@
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared types, codes and helpers for the pairing handshake slave core.
// ----------------------------------------------------------------------------
package rfps_pkg;

   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned AddrWidth    = 40;
   localparam int unsigned MagicWidth   = 32;
   localparam int unsigned CountWidth   = 8;
   localparam int unsigned TimeoutWidth = 16;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 40;

   localparam logic [CountWidth-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SEND   = 3'd1,
      PH_WAIT   = 3'd2,
      PH_VERIFY = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE     = 4'd0,
      EV_START    = 4'd1,
      EV_SEND     = 4'd2,
      EV_SWITCH   = 4'd3,
      EV_PONG     = 4'd4,
      EV_VFAIL    = 4'd5,
      EV_RTIMEOUT = 4'd6,
      EV_SAVE     = 4'd7,
      EV_STOP     = 4'd8
   } event_type;

   typedef enum logic [1:0] {
      RX_NONE  = 2'd0,
      RX_REPLY = 2'd1,
      RX_PING  = 2'd2,
      RX_OTHER = 2'd3
   } rx_kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEVICE_TYPE   = 3'd0,
      CSR_ADDRESS_MODE  = 3'd1,
      CSR_OWN_ADDRESS   = 3'd2,
      CSR_VERIFY_TARGET = 3'd3,
      CSR_HOST_MAGIC    = 3'd4,
      CSR_REPLY_TMO     = 3'd5,
      CSR_VERIFY_TMO    = 3'd6,
      CSR_SILENCE_TMO   = 3'd7
   } csr_index_type;

   localparam logic [CountWidth-1:0]   VerifyTargetReset = 8'd5;
   localparam logic [TimeoutWidth-1:0] ReplyTmoReset     = 16'd100;
   localparam logic [TimeoutWidth-1:0] VerifyTmoReset    = 16'd5000;
   localparam logic [TimeoutWidth-1:0] SilenceTmoReset   = 16'd3000;

   typedef struct packed {
      logic [CountWidth-1:0]   verify_target;
      logic [MagicWidth-1:0]   host_magic;
      logic [TimeoutWidth-1:0] reply_timeout_ms;
      logic [TimeoutWidth-1:0] verify_timeout_ms;
      logic [TimeoutWidth-1:0] silence_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic                  enable;
      logic [TimeWidth-1:0]  now_ms;
      logic [1:0]            rx_kind;
      logic [MagicWidth-1:0] rx_magic;
      logic [AddrWidth-1:0]  rx_new_address;
   } req_type;

   typedef struct packed {
      event_type             event_res;
      logic [AddrWidth-1:0]  link_address;
      logic [CountWidth-1:0] verify_count;
      phase_type             phase;
      logic                  goal_reached;
   } rsp_type;

   // Wrapped time difference strictly above the limit.
   function automatic logic elapsed(input logic [TimeWidth-1:0]    now,
                                    input logic [TimeWidth-1:0]    since,
                                    input logic [TimeoutWidth-1:0] limit);
      logic [TimeWidth-1:0] diff;
      diff = now - since;
      return diff > {{(TimeWidth-TimeoutWidth){1'b0}}, limit};
   endfunction

endpackage

@@ sv/rf_pairing_slave_handshake_core.sv @@
// ----------------------------------------------------------------------------
// rf_pairing_slave_handshake_core
// Slave side of the radio pairing handshake, one poll per request.
// ----------------------------------------------------------------------------
// Each request is one poll (enable flag, millisecond time, one classified
// packet) and yields exactly one response with the event, the link address,
// the ping count, the phase and the goal flag after that poll. The core takes
// one request per clock while the response side is not stalled; a request is
// registered on entry, stepped through the phase machine in one pass and
// registered again at the response port. The response register frees as the
// downstream side takes its response, so a stall costs no extra bubble.
// Write configuration only while
// no request is in flight.
module rf_pairing_slave_handshake_core
   import rfps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_wr_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_enable,
   input  logic [TimeWidth-1:0]    req_now_ms,
   input  logic [1:0]              req_rx_kind,
   input  logic [MagicWidth-1:0]   req_rx_magic,
   input  logic [AddrWidth-1:0]    req_rx_new_address,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [3:0]              rsp_event_res,
   output logic [AddrWidth-1:0]    rsp_link_address,
   output logic [CountWidth-1:0]   rsp_verify_count,
   output logic [2:0]              rsp_phase,
   output logic                    rsp_goal_reached
);

   cfg_type cfg;
   req_type s1_req_ff;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type step_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_ready;
   logic    advance;
   logic    s1_load;

   rfps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfps_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (s1_req_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_ready ? advance : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on load or advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff.enable         <= req_enable;
         s1_req_ff.now_ms         <= req_now_ms;
         s1_req_ff.rx_kind        <= req_rx_kind;
         s1_req_ff.rx_magic       <= req_rx_magic;
         s1_req_ff.rx_new_address <= req_rx_new_address;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ff.event_res;
   assign rsp_link_address = rsp_ff.link_address;
   assign rsp_verify_count = rsp_ff.verify_count;
   assign rsp_phase        = rsp_ff.phase;
   assign rsp_goal_reached = rsp_ff.goal_reached;

   a_stall_needs_held_request: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stall raised with empty input register");

   a_save_in_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_SAVE) |-> rsp_phase == PH_DONE)
      else $error("save event outside done phase");

   a_start_clears_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_START) |->
         (rsp_phase == PH_SEND && rsp_verify_count == '0 && !rsp_goal_reached))
      else $error("start event without cleared run");

   a_address_only_on_link_events: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_event_res == EV_SWITCH || rsp_event_res == EV_PONG ||
                      rsp_event_res == EV_SAVE)) |-> rsp_link_address == '0)
      else $error("link address shown on an event that carries none");

endmodule

@@ sv/rfps_csr.sv @@
// ----------------------------------------------------------------------------
// rfps_csr
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module rfps_csr
   import rfps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Device type, address mode and own address only feed request assembly,
   // which sits outside this core, so they are accepted and dropped here.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VERIFY_TARGET: cfg_in.verify_target      = csr_wdata[CountWidth-1:0];
            CSR_HOST_MAGIC:    cfg_in.host_magic         = csr_wdata[MagicWidth-1:0];
            CSR_REPLY_TMO:     cfg_in.reply_timeout_ms   = csr_wdata[TimeoutWidth-1:0];
            CSR_VERIFY_TMO:    cfg_in.verify_timeout_ms  = csr_wdata[TimeoutWidth-1:0];
            CSR_SILENCE_TMO:   cfg_in.silence_timeout_ms = csr_wdata[TimeoutWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.verify_target      <= VerifyTargetReset;
         cfg_ff.host_magic         <= '0;
         cfg_ff.reply_timeout_ms   <= ReplyTmoReset;
         cfg_ff.verify_timeout_ms  <= VerifyTmoReset;
         cfg_ff.silence_timeout_ms <= SilenceTmoReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/rfps_core.sv @@
// ----------------------------------------------------------------------------
// rfps_core
// Pairing phase machine: state registers and the single-pass step logic.
// ----------------------------------------------------------------------------
module rfps_core
   import rfps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type              phase_ff, phase_in;
   logic                   was_en_ff, was_en_in;
   logic [TimeWidth-1:0]   wait_start_ff, wait_start_in;
   logic [TimeWidth-1:0]   last_ping_ff, last_ping_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   goal_ff, goal_in;
   logic [AddrWidth-1:0]   addr_ff, addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         was_en_ff     <= 1'b0;
         wait_start_ff <= '0;
         last_ping_ff  <= '0;
         count_ff      <= '0;
         goal_ff       <= 1'b0;
         addr_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         was_en_ff     <= was_en_in;
         wait_start_ff <= wait_start_in;
         last_ping_ff  <= last_ping_in;
         count_ff      <= count_in;
         goal_ff       <= goal_in;
         addr_ff       <= addr_in;
      end
   end

   always_comb begin
      logic                  ping_ok;
      logic [CountWidth-1:0] count_inc;
      event_type             ev;
      logic                  show_addr;

      phase_in      = phase_ff;
      was_en_in     = was_en_ff;
      wait_start_in = wait_start_ff;
      last_ping_in  = last_ping_ff;
      count_in      = count_ff;
      goal_in       = goal_ff;
      addr_in       = addr_ff;
      ev            = EV_NONE;
      show_addr     = 1'b0;
      ping_ok       = (rx_kind_type'(req.rx_kind) == RX_PING) &&
                      (req.rx_magic == cfg.host_magic);
      count_inc     = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;

      if (!req.enable) begin
         if (was_en_ff) begin
            phase_in = PH_IDLE;
            ev       = EV_STOP;
         end
         was_en_in = 1'b0;
      end else begin
         // Rising enable: clear the run and fall through from idle.
         if (!was_en_ff) begin
            phase_in      = PH_IDLE;
            wait_start_in = '0;
            last_ping_in  = '0;
            count_in      = '0;
            goal_in       = 1'b0;
            addr_in       = '0;
            ev            = EV_START;
            count_inc     = {{(CountWidth-1){1'b0}}, 1'b1};
         end
         was_en_in = 1'b1;

         unique case (phase_in)
            PH_IDLE: begin
               phase_in = PH_SEND;
            end
            PH_SEND: begin
               wait_start_in = req.now_ms;
               phase_in      = PH_WAIT;
               ev            = EV_SEND;
            end
            PH_WAIT: begin
               if (rx_kind_type'(req.rx_kind) == RX_REPLY) begin
                  addr_in       = req.rx_new_address;
                  count_in      = '0;
                  goal_in       = 1'b0;
                  last_ping_in  = req.now_ms;
                  wait_start_in = req.now_ms;
                  phase_in      = PH_VERIFY;
                  ev            = EV_SWITCH;
                  show_addr     = 1'b1;
               end else if (elapsed(req.now_ms, wait_start_ff, cfg.reply_timeout_ms)) begin
                  phase_in = PH_SEND;
                  ev       = EV_RTIMEOUT;
               end
            end
            PH_VERIFY: begin
               // A valid ping resets both timers, so no timeout can fire with it.
               if (ping_ok) begin
                  wait_start_in = req.now_ms;
                  last_ping_in  = req.now_ms;
                  count_in      = count_inc;
                  goal_in       = goal_ff || (count_inc >= cfg.verify_target);
                  ev            = EV_PONG;
                  show_addr     = 1'b1;
               end else if (goal_ff) begin
                  if (elapsed(req.now_ms, last_ping_ff, cfg.silence_timeout_ms)) begin
                     phase_in = PH_DONE;
                  end
               end else if (elapsed(req.now_ms, wait_start_ff, cfg.verify_timeout_ms)) begin
                  phase_in = PH_SEND;
                  ev       = EV_VFAIL;
               end
            end
            PH_DONE: begin
               ev        = EV_SAVE;
               show_addr = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      rsp.event_res    = ev;
      rsp.link_address = show_addr ? addr_in : '0;
      rsp.verify_count = count_in;
      rsp.phase        = phase_in;
      rsp.goal_reached = goal_in;
   end

endmodule

@@ sim/tb_rf_pairing_slave_handshake_core.sv @@
// ----------------------------------------------------------------------------
// tb_rf_pairing_slave_handshake_core
// Self-checking bench for the pairing handshake slave core.
// ----------------------------------------------------------------------------
// Polls are pushed through the request channel with random gaps, and the
// response channel is stalled at random. An in-bench copy of the phase machine
// predicts one response per accepted poll, and a checker compares every
// response field against the oldest prediction. Directed runs cover the reset
// settings, the register extremes and count saturation. Random pairing
// sessions then run under several register settings, including wrapping time.
// ----------------------------------------------------------------------------
module tb_rf_pairing_slave_handshake_core
   import rfps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_enable = 1'b0;
   logic [TimeWidth-1:0]    req_now_ms = '0;
   logic [1:0]              req_rx_kind = '0;
   logic [MagicWidth-1:0]   req_rx_magic = '0;
   logic [AddrWidth-1:0]    req_rx_new_address = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [3:0]              rsp_event_res;
   logic [AddrWidth-1:0]    rsp_link_address;
   logic [CountWidth-1:0]   rsp_verify_count;
   logic [2:0]              rsp_phase;
   logic                    rsp_goal_reached;

   rf_pairing_slave_handshake_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_enable         (req_enable),
      .req_now_ms         (req_now_ms),
      .req_rx_kind        (req_rx_kind),
      .req_rx_magic       (req_rx_magic),
      .req_rx_new_address (req_rx_new_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_link_address   (rsp_link_address),
      .rsp_verify_count   (rsp_verify_count),
      .rsp_phase          (rsp_phase),
      .rsp_goal_reached   (rsp_goal_reached)
   );

   always #4 clock = ~clock;

   // Pairing state as the core should hold it
   cfg_type               pair_cfg;
   phase_type             pair_phase = PH_IDLE;
   logic                  pair_enabled = 1'b0;
   logic [TimeWidth-1:0]  reply_wait_ms = '0;
   logic [TimeWidth-1:0]  last_ping_at = '0;
   logic [CountWidth-1:0] ping_total = '0;
   logic                  goal_hit = 1'b0;
   logic [AddrWidth-1:0]  link_addr = '0;

   rsp_type               poll_result_q[$];
   rsp_type               want_rsp;
   logic [TimeWidth-1:0]  wall_ms = '0;
   bit                    idle_on = 1'b1;
   int                    stall_left = 0;
   int                    mismatches = 0;
   int                    polls_sent = 0;
   int                    responses_checked = 0;
   int                    settings_written = 0;
   int                    ev_seen[16];

   function automatic logic past_limit(input logic [TimeWidth-1:0] now,
                                       input logic [TimeWidth-1:0] since,
                                       input logic [TimeoutWidth-1:0] limit);
      logic [TimeWidth-1:0] gap;
      gap = now - since;
      return gap > TimeWidth'(limit);
   endfunction

   // Advance the pairing state by one poll and return the response it gives
   function automatic rsp_type pairing_step(input logic en,
                                            input logic [TimeWidth-1:0] now,
                                            input logic [1:0] kind,
                                            input logic [MagicWidth-1:0] magic,
                                            input logic [AddrWidth-1:0] naddr);
      rsp_type   r;
      event_type ev;
      logic      show;
      ev = EV_NONE;
      show = 1'b0;
      if (!en) begin
         if (pair_enabled) begin
            pair_phase = PH_IDLE;
            ev = EV_STOP;
         end
         pair_enabled = 1'b0;
      end else begin
         if (!pair_enabled) begin
            pair_enabled = 1'b1;
            pair_phase = PH_IDLE;
            reply_wait_ms = '0;
            last_ping_at = '0;
            ping_total = '0;
            goal_hit = 1'b0;
            link_addr = '0;
            ev = EV_START;
         end
         case (pair_phase)
            PH_IDLE: pair_phase = PH_SEND;
            PH_SEND: begin
               reply_wait_ms = now;
               pair_phase = PH_WAIT;
               ev = EV_SEND;
            end
            PH_WAIT: begin
               if (kind == RX_REPLY) begin
                  link_addr = naddr;
                  ping_total = '0;
                  goal_hit = 1'b0;
                  last_ping_at = now;
                  reply_wait_ms = now;
                  pair_phase = PH_VERIFY;
                  ev = EV_SWITCH;
                  show = 1'b1;
               end else if (past_limit(now, reply_wait_ms, pair_cfg.reply_timeout_ms)) begin
                  pair_phase = PH_SEND;
                  ev = EV_RTIMEOUT;
               end
            end
            PH_VERIFY: begin
               if (kind == RX_PING && magic == pair_cfg.host_magic) begin
                  reply_wait_ms = now;
                  last_ping_at = now;
                  if (ping_total != CountMax) ping_total++;
                  if (ping_total >= pair_cfg.verify_target) goal_hit = 1'b1;
                  ev = EV_PONG;
                  show = 1'b1;
               end
               if (goal_hit) begin
                  if (past_limit(now, last_ping_at, pair_cfg.silence_timeout_ms))
                     pair_phase = PH_DONE;
               end else if (past_limit(now, reply_wait_ms, pair_cfg.verify_timeout_ms)) begin
                  pair_phase = PH_SEND;
                  ev = EV_VFAIL;
               end
            end
            PH_DONE: begin
               ev = EV_SAVE;
               show = 1'b1;
            end
            default: pair_phase = PH_IDLE;
         endcase
      end
      r.event_res = ev;
      r.link_address = show ? link_addr : '0;
      r.verify_count = ping_total;
      r.phase = pair_phase;
      r.goal_reached = goal_hit;
      return r;
   endfunction

   // Hold one poll on the request port until the core takes it
   task automatic send_poll(input logic en, input logic [TimeWidth-1:0] now,
                            input logic [1:0] kind, input logic [MagicWidth-1:0] magic,
                            input logic [AddrWidth-1:0] naddr);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_enable <= en;
      req_now_ms <= now;
      req_rx_kind <= kind;
      req_rx_magic <= magic;
      req_rx_new_address <= naddr;
      do @(posedge clock); while (req_stall);
      poll_result_q.push_back(pairing_step(en, now, kind, magic, naddr));
      polls_sent++;
   endtask

   // Drop valid and wait until every predicted response has been taken
   task automatic wait_results_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (poll_result_q.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (poll_result_q.size() != 0) begin
         $error("%0d responses still outstanding", poll_result_q.size());
         mismatches++;
         poll_result_q.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [CsrDataWidth-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] dev, input logic mode,
                               input logic [AddrWidth-1:0] own,
                               input logic [CountWidth-1:0] target,
                               input logic [MagicWidth-1:0] magic,
                               input logic [TimeoutWidth-1:0] rtmo,
                               input logic [TimeoutWidth-1:0] vtmo,
                               input logic [TimeoutWidth-1:0] stmo);
      csr_put(CSR_DEVICE_TYPE, CsrDataWidth'(dev));
      csr_put(CSR_ADDRESS_MODE, CsrDataWidth'(mode));
      csr_put(CSR_OWN_ADDRESS, own);
      csr_put(CSR_VERIFY_TARGET, CsrDataWidth'(target));
      csr_put(CSR_HOST_MAGIC, CsrDataWidth'(magic));
      csr_put(CSR_REPLY_TMO, CsrDataWidth'(rtmo));
      csr_put(CSR_VERIFY_TMO, CsrDataWidth'(vtmo));
      csr_put(CSR_SILENCE_TMO, CsrDataWidth'(stmo));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      pair_cfg.verify_target = target;
      pair_cfg.host_magic = magic;
      pair_cfg.reply_timeout_ms = rtmo;
      pair_cfg.verify_timeout_ms = vtmo;
      pair_cfg.silence_timeout_ms = stmo;
      settings_written++;
   endtask

   function automatic logic [TimeWidth-1:0] pick_delta(input logic [TimeoutWidth-1:0] lim);
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return TimeWidth'(lim);
         3: return TimeWidth'(lim) + 1;
         4: return $urandom;
         default: return TimeWidth'($urandom_range(1, 1 + lim / 4));
      endcase
   endfunction

   // Pick a poll that fits the current phase most of the time
   task automatic guided_poll(input logic en);
      int                    r;
      logic [1:0]            kind;
      logic [MagicWidth-1:0] magic;
      logic [AddrWidth-1:0]  naddr;
      logic [TimeoutWidth-1:0] lim;
      r = $urandom_range(0, 9);
      magic = $urandom;
      naddr[39:32] = 8'($urandom);
      naddr[31:0] = $urandom;
      kind = 2'($urandom_range(0, 3));
      lim = 16'd20;
      if (pair_phase == PH_WAIT) begin
         lim = pair_cfg.reply_timeout_ms;
         if (r < 4) kind = RX_REPLY;
         else if (r < 7) kind = RX_NONE;
      end else if (pair_phase == PH_VERIFY) begin
         lim = goal_hit ? pair_cfg.silence_timeout_ms : pair_cfg.verify_timeout_ms;
         if (r < 7) begin
            kind = RX_PING;
            magic = pair_cfg.host_magic;
            // near miss on the magic
            if (r == 6) magic[$urandom_range(0, 31)] ^= 1'b1;
         end
      end
      wall_ms += pick_delta(lim);
      send_poll(en, wall_ms, kind, magic, naddr);
   endtask

   task automatic run_session();
      int polls;
      if ($urandom_range(0, 9) == 0) wait_results_idle();
      polls = $urandom_range(3, 40);
      repeat (polls) guided_poll($urandom_range(0, 39) != 0);
      repeat ($urandom_range(1, 3)) guided_poll(1'b0);
   endtask

   task automatic test_reset_defaults();
      wall_ms = 32'h0000_1000;
      send_poll(1'b0, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_OTHER, '0, '0);
      wall_ms += 100;
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      wall_ms += 1;
      // ping while waiting for the reply: drop it, the resend still fires
      send_poll(1'b1, wall_ms, RX_PING, '0, '0);
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_REPLY, '0, 40'hA5_5A5A_A5A5);
      wall_ms += 5001;
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      wait_results_idle();
   endtask

   task automatic test_register_extremes();
      write_config(8'hFF, 1'b1, '1, 8'd0, 32'hFFFF_FFFF, '0, '0, '0);
      wall_ms = 32'hFFFF_FFFE;
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_REPLY, '0, '1);
      send_poll(1'b1, wall_ms, RX_PING, 32'hFFFF_FFFE, '0);
      send_poll(1'b1, wall_ms, RX_REPLY, '0, '0);
      // target zero: the first good ping reaches the goal
      send_poll(1'b1, wall_ms, RX_PING, 32'hFFFF_FFFF, '0);
      wall_ms += 2;
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_OTHER, '1, '1);
      send_poll(1'b1, wall_ms, RX_PING, 32'hFFFF_FFFF, '0);
      send_poll(1'b0, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b0, wall_ms, RX_REPLY, '1, '1);
      wait_results_idle();
   endtask

   task automatic test_count_saturation();
      logic [MagicWidth-1:0] magic;
      magic = $urandom;
      write_config(8'h00, 1'b0, '0, 8'd255, magic, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      wall_ms = $urandom;
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_REPLY, '0, 40'h12_3456_789A);
      repeat (262) begin
         wall_ms += 1;
         send_poll(1'b1, wall_ms, RX_PING, magic, '0);
      end
      wall_ms += 32'h0001_0000;
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b1, wall_ms, RX_NONE, '0, '0);
      send_poll(1'b0, wall_ms, RX_NONE, '0, '0);
      wait_results_idle();
   endtask

   task automatic test_random_runs();
      int phase_start;
      for (int p = 0; p < 6; p++) begin
         wall_ms = $urandom;
         case (p)
            0, 5: write_config(8'($urandom), 1'b0, '0, 8'($urandom_range(1, 4)), $urandom,
                               16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                               16'($urandom_range(0, 30)));
            1: write_config(8'h00, 1'b1, {8'($urandom), 32'($urandom)}, 8'd1, '0,
                            '0, '0, '0);
            2: begin
               write_config(8'hFF, 1'b1, '1, 8'($urandom_range(2, 6)), 32'hFFFF_FFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF);
               wall_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
            end
            3: write_config(8'($urandom), 1'($urandom), {8'($urandom), 32'($urandom)},
                            8'd0, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
            default: write_config(8'($urandom), 1'($urandom), '0, 8'($urandom_range(1, 3)),
                                  $urandom, 16'($urandom_range(1, 200)),
                                  16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)));
         endcase
         // finish without any gaps or stalls
         idle_on = (p != 5);
         phase_start = polls_sent;
         while (polls_sent < phase_start + 260) run_session();
         wait_results_idle();
      end
   endtask

   // Random stall bursts on the response side
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (poll_result_q.size() == 0) begin
            $error("response with no poll outstanding, event_res %0d", rsp_event_res);
            mismatches++;
         end else begin
            want_rsp = poll_result_q.pop_front();
            responses_checked++;
            ev_seen[want_rsp.event_res]++;
            if (rsp_event_res !== want_rsp.event_res) begin
               $error("event_res expected %0d got %0d", want_rsp.event_res, rsp_event_res);
               mismatches++;
            end
            if (rsp_link_address !== want_rsp.link_address) begin
               $error("link_address expected %h got %h", want_rsp.link_address,
                      rsp_link_address);
               mismatches++;
            end
            if (rsp_verify_count !== want_rsp.verify_count) begin
               $error("verify_count expected %0d got %0d", want_rsp.verify_count,
                      rsp_verify_count);
               mismatches++;
            end
            if (rsp_phase !== want_rsp.phase) begin
               $error("phase expected %0d got %0d", want_rsp.phase, rsp_phase);
               mismatches++;
            end
            if (rsp_goal_reached !== want_rsp.goal_reached) begin
               $error("goal_reached expected %0d got %0d", want_rsp.goal_reached,
                      rsp_goal_reached);
               mismatches++;
            end
         end
      end
   end

   initial begin
      pair_cfg.verify_target = VerifyTargetReset;
      pair_cfg.host_magic = '0;
      pair_cfg.reply_timeout_ms = ReplyTmoReset;
      pair_cfg.verify_timeout_ms = VerifyTmoReset;
      pair_cfg.silence_timeout_ms = SilenceTmoReset;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_count_saturation();
      test_random_runs();
      wait_results_idle();
      $display("Checked %0d responses to %0d polls under %0d register settings.",
               responses_checked, polls_sent, settings_written + 1);
      $display(
         "Events: start %0d request %0d switch %0d pong %0d vfail %0d rtmo %0d save %0d stop %0d",
         ev_seen[EV_START], ev_seen[EV_SEND], ev_seen[EV_SWITCH], ev_seen[EV_PONG],
         ev_seen[EV_VFAIL], ev_seen[EV_RTIMEOUT], ev_seen[EV_SAVE], ev_seen[EV_STOP]);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Run timed out with %0d responses outstanding", poll_result_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
